[hdl/sadp_pkg.sv]
// Shared types, character constants and error text for the signed ALU decimal printer.
`timescale 1ns / 1ps

package sadp_pkg;

	localparam int FUNC_W    = 3;
	localparam int OPERAND_W = 32;
	localparam int CHAR_W    = 8;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD = 3'd0,
		FUNC_SUB = 3'd1,
		FUNC_MUL = 3'd2,
		FUNC_DIV = 3'd3,
		FUNC_REM = 3'd4
	} func_t;

	typedef struct packed {
		logic skip;
		logic text;
		logic text_mod;
		logic neg;
	} res_ctl_t;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	localparam int DIV_TEXT_LEN = 23;
	localparam int MOD_TEXT_LEN = 21;
	localparam int TEXT_IDX_W   = 5;

	localparam logic [CHAR_W*DIV_TEXT_LEN-1:0] DIV_TEXT = "Stop : division by zero";
	localparam logic [CHAR_W*MOD_TEXT_LEN-1:0] MOD_TEXT = "Stop : modulo by zero";

	function automatic logic [CHAR_W-1:0] err_char(input logic text_mod,
			input logic [TEXT_IDX_W-1:0] idx);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		if (text_mod) begin
			if (int'(idx) < MOD_TEXT_LEN)
				ch = MOD_TEXT[CHAR_W*(MOD_TEXT_LEN-1-int'(idx)) +: CHAR_W];
		end else begin
			if (int'(idx) < DIV_TEXT_LEN)
				ch = DIV_TEXT[CHAR_W*(DIV_TEXT_LEN-1-int'(idx)) +: CHAR_W];
		end
		return ch;
	endfunction

endpackage

[hdl/sadp_if.sv]
// Valid/ready channel interfaces: command word in, character word out.
`timescale 1ns / 1ps

interface sadp_in_if
	import sadp_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [OPERAND_W-1:0] operand_a;
	logic [OPERAND_W-1:0] operand_b;

	modport source(output valid, func, operand_a, operand_b, input ready);
	modport sink(input valid, func, operand_a, operand_b, output ready);
endinterface

interface sadp_out_if
	import sadp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              last_char;
	logic              status;

	modport source(output valid, out_char, last_char, status, input ready);
	modport sink(input valid, out_char, last_char, status, output ready);
endinterface

[hdl/sadp_alu.sv]
// Iterative ALU: bit-serial add/subtract, shift-add multiply, restoring divide.
`timescale 1ns / 1ps

module sadp_alu
	import sadp_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [FUNC_W-1:0]     func,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic                  done,
	output res_ctl_t              ctl,
	output logic [DATA_WIDTH-1:0] mag
);

	localparam int CNT_W = $clog2(DATA_WIDTH);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

	state_t                state_q;
	func_t                 op_q;
	logic [DATA_WIDTH-1:0] x_q;
	logic [DATA_WIDTH-1:0] y_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  cy_q;
	logic                  sa_q;
	logic                  sb_q;
	logic                  done_q;
	res_ctl_t              ctl_q;
	logic [DATA_WIDTH-1:0] mag_q;

	logic [DATA_WIDTH-1:0] a_mag;
	logic [DATA_WIDTH-1:0] b_mag;
	logic                  s_bit;
	logic                  cy_n;
	logic [DATA_WIDTH-1:0] mul_sum;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH-1:0] res_mag;
	logic                  q_nz;
	logic                  q_min;

	assign a_mag   = a[DATA_WIDTH-1] ? (~a + DATA_WIDTH'(1)) : a;
	assign b_mag   = b[DATA_WIDTH-1] ? (~b + DATA_WIDTH'(1)) : b;
	assign s_bit   = x_q[0] ^ y_q[0] ^ cy_q;
	assign cy_n    = (x_q[0] & y_q[0]) | (cy_q & (x_q[0] ^ y_q[0]));
	assign mul_sum = acc_q + (y_q[0] ? x_q : '0);
	assign trial   = {acc_q, x_q[DATA_WIDTH-1]} - {1'b0, y_q};
	assign res_mag = acc_q[DATA_WIDTH-1] ? (~acc_q + DATA_WIDTH'(1)) : acc_q;
	assign q_nz    = |x_q;
	assign q_min   = (x_q == {1'b1, {(DATA_WIDTH-1){1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q  <= func_t'(func);
						sa_q  <= a[DATA_WIDTH-1];
						sb_q  <= b[DATA_WIDTH-1];
						cy_q  <= (func == FUNC_SUB);
						acc_q <= '0;
						cnt_q <= CNT_W'(DATA_WIDTH-1);
						unique case (func_t'(func))
							FUNC_ADD, FUNC_MUL: begin
								x_q     <= a;
								y_q     <= b;
								ctl_q   <= '0;
								done_q  <= 1'b0;
								state_q <= S_RUN;
							end
							FUNC_SUB: begin
								x_q     <= a;
								y_q     <= ~b;
								ctl_q   <= '0;
								done_q  <= 1'b0;
								state_q <= S_RUN;
							end
							FUNC_DIV, FUNC_REM: begin
								x_q <= a_mag;
								y_q <= b_mag;
								if (b == '0) begin
									ctl_q  <= '{skip: 1'b0, text: 1'b1,
										text_mod: (func == FUNC_REM), neg: 1'b0};
									done_q <= 1'b1;
								end else begin
									ctl_q   <= '0;
									done_q  <= 1'b0;
									state_q <= S_RUN;
								end
							end
							default: begin
								ctl_q  <= '{skip: 1'b1, text: 1'b0, text_mod: 1'b0,
									neg: 1'b0};
								done_q <= 1'b1;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				S_RUN: begin
					done_q <= 1'b0;
					unique case (op_q)
						FUNC_ADD, FUNC_SUB: begin
							acc_q <= {s_bit, acc_q[DATA_WIDTH-1:1]};
							x_q   <= x_q >> 1;
							y_q   <= y_q >> 1;
							cy_q  <= cy_n;
						end
						FUNC_MUL: begin
							acc_q <= mul_sum;
							x_q   <= x_q << 1;
							y_q   <= y_q >> 1;
						end
						FUNC_DIV, FUNC_REM: begin
							if (!trial[DATA_WIDTH]) begin
								acc_q <= trial[DATA_WIDTH-1:0];
								x_q   <= {x_q[DATA_WIDTH-2:0], 1'b1};
							end else begin
								acc_q <= {acc_q[DATA_WIDTH-2:0], x_q[DATA_WIDTH-1]};
								x_q   <= {x_q[DATA_WIDTH-2:0], 1'b0};
							end
						end
						default: ;
					endcase
					if (cnt_q == '0)
						state_q <= S_FIX;
					else
						cnt_q <= cnt_q - CNT_W'(1);
				end
				S_FIX: begin
					unique case (op_q)
						FUNC_DIV: begin
							mag_q     <= x_q;
							ctl_q.neg <= ((sa_q ^ sb_q) && q_nz) || q_min;
						end
						FUNC_REM: begin
							mag_q     <= acc_q;
							ctl_q.neg <= sa_q && (|acc_q);
						end
						default: begin
							mag_q     <= res_mag;
							ctl_q.neg <= acc_q[DATA_WIDTH-1];
						end
					endcase
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign ctl  = ctl_q;
	assign mag  = mag_q;

endmodule

[hdl/sadp_emit.sv]
// Double-dabble decimal conversion and an output register giving one character per cycle while chr is ready.
`timescale 1ns / 1ps

module sadp_emit
	import sadp_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  res_ctl_t              ctl,
	input  logic [DATA_WIDTH-1:0] mag,
	sadp_out_if.source            chr
);

	localparam int NUM_DIG = (DATA_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_W   = 4 * NUM_DIG;
	localparam int DIG_W   = $clog2(NUM_DIG);
	localparam int CNT_W   = $clog2(DATA_WIDTH);

	typedef enum logic [2:0] {E_IDLE, E_CONV, E_SKIP, E_SIGN, E_DIGIT, E_TEXT} state_t;

	state_t                  state_q;
	logic [DATA_WIDTH-1:0]   bin_q;
	logic [BCD_W-1:0]        bcd_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIG_W-1:0]        dig_q;
	logic                    neg_q;
	logic                    mod_q;
	logic [TEXT_IDX_W-1:0]   idx_q;
	logic                    vld_q;
	logic [CHAR_W-1:0]       char_q;
	logic                    last_q;
	logic                    stat_q;

	logic [BCD_W-1:0] bcd_adj;
	logic [3:0]       top_dig;
	logic             slot;
	logic             text_last;
	logic             emit_word;

	always_comb begin
		for (int i = 0; i < NUM_DIG; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
				: bcd_q[4*i +: 4];
		end
	end

	assign top_dig   = bcd_q[BCD_W-1 -: 4];
	assign slot      = !vld_q || chr.ready;
	assign text_last = (idx_q == (mod_q ? TEXT_IDX_W'(MOD_TEXT_LEN-1)
		: TEXT_IDX_W'(DIV_TEXT_LEN-1)));
	assign emit_word = slot && (state_q == E_SIGN || state_q == E_DIGIT
		|| state_q == E_TEXT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= emit_word || (vld_q && !chr.ready);
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						neg_q <= ctl.neg;
						mod_q <= ctl.text_mod;
						idx_q <= '0;
						bin_q <= mag;
						bcd_q <= '0;
						cnt_q <= CNT_W'(DATA_WIDTH-1);
						state_q <= ctl.text ? E_TEXT : E_CONV;
					end
				end
				E_CONV: begin
					bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[DATA_WIDTH-1]};
					bin_q <= bin_q << 1;
					if (cnt_q == '0) begin
						dig_q   <= DIG_W'(NUM_DIG-1);
						state_q <= E_SKIP;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				E_SKIP: begin
					if (top_dig == 4'd0 && dig_q != '0) begin
						bcd_q <= bcd_q << 4;
						dig_q <= dig_q - DIG_W'(1);
					end else begin
						state_q <= neg_q ? E_SIGN : E_DIGIT;
					end
				end
				E_SIGN: begin
					if (slot) begin
						char_q  <= CHAR_MINUS;
						last_q  <= 1'b0;
						stat_q  <= 1'b0;
						state_q <= E_DIGIT;
					end
				end
				E_DIGIT: begin
					if (slot) begin
						char_q <= CHAR_ZERO + CHAR_W'(top_dig);
						last_q <= (dig_q == '0);
						stat_q <= 1'b0;
						bcd_q  <= bcd_q << 4;
						if (dig_q == '0)
							state_q <= E_IDLE;
						else
							dig_q <= dig_q - DIG_W'(1);
					end
				end
				E_TEXT: begin
					if (slot) begin
						char_q <= err_char(mod_q, idx_q);
						last_q <= text_last;
						stat_q <= 1'b1;
						idx_q  <= idx_q + TEXT_IDX_W'(1);
						if (text_last)
							state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign chr.valid     = vld_q;
	assign chr.out_char  = char_q;
	assign chr.last_char = last_q;
	assign chr.status    = stat_q;

endmodule

[hdl/signed_alu_decimal_printer.sv]
// Top level: signed ALU with decimal ASCII character output.
//
//   channel | modport | word
//   cmd     | sink    | func, operand_a, operand_b
//   chr     | source  | out_char, last_char, status
//
// One command at a time; cmd.ready is high only while no word is in flight.
// Number, accept to next accept: the ALU loads, iterates and fixes up the sign, hands off to
// the emitter, which runs double-dabble, skips leading zeros, sends an optional minus sign
// and the digits, and frees cmd when the last character is taken.
// Zero divisor: error text replaces the digits. Unused func codes: no output. Stalls on chr
// hold the output register. Reset clears states, done, valid and busy; no memory to clear.
`timescale 1ns / 1ps

module signed_alu_decimal_printer
	import sadp_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	sadp_in_if.sink     cmd,
	sadp_out_if.source  chr
);

	logic                  busy_q;
	logic                  start;
	logic                  alu_done;
	res_ctl_t              alu_ctl;
	logic [DATA_WIDTH-1:0] alu_mag;
	logic                  last_take;

	assign cmd.ready = !busy_q;
	assign start     = cmd.valid && cmd.ready;
	assign last_take = chr.valid && chr.ready && chr.last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			if (start)
				busy_q <= 1'b1;
			else if ((alu_done && alu_ctl.skip) || last_take)
				busy_q <= 1'b0;
		end
	end

	sadp_alu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (cmd.func),
		.a     (cmd.operand_a[DATA_WIDTH-1:0]),
		.b     (cmd.operand_b[DATA_WIDTH-1:0]),
		.done  (alu_done),
		.ctl   (alu_ctl),
		.mag   (alu_mag)
	);

	sadp_emit #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_emit (
		.clk   (clk),
		.arst_n(arst_n),
		.start (alu_done && !alu_ctl.skip),
		.ctl   (alu_ctl),
		.mag   (alu_mag),
		.chr   (chr)
	);

`ifndef SYNTHESIS
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chr.valid |-> busy_q)
		else $error("output word while no command in flight");

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> !chr.valid)
		else $error("ALU result while output register still full");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		last_take |=> !busy_q)
		else $error("busy held after last character taken");
`endif

endmodule
